### src/imtt_pkg.sv
// Shared constants and types for the indexed-to-Morton tiled texture converter.
package imtt_pkg;

    localparam int MAX_DIM_DEF     = 1024;
    localparam int PAL_ENTRIES_DEF = 256;

    localparam int TILE_EDGE   = 8;
    localparam int TILE_TEXELS = TILE_EDGE * TILE_EDGE;
    localparam int POS_W       = $clog2(TILE_TEXELS);
    localparam int CFG_W       = 11;
    localparam int TILES_W     = CFG_W - 2;
    localparam int TEXEL_W     = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        MODE_PIXEL   = 1'b0,
        MODE_PALETTE = 1'b1
    } imtt_mode_t;

    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } imtt_reg_t;

    // one converted pixel on its way to the tile store
    typedef struct packed {
        logic [TEXEL_W-1:0] texel;
        logic [POS_W-1:0]   pos;
        logic               last_tex;
    } imtt_pix_t;

endpackage

### src/imtt_front.sv
// Front end: palette memory, position counters and texel conversion.
module imtt_front
    import imtt_pkg::*;
#(
    parameter int MAX_DIMENSION   = MAX_DIM_DEF,
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic [7:0]         pixel_index,
    input  logic [7:0]         palette_address,
    input  logic [15:0]        palette_color,
    input  logic [CFG_W-1:0]   source_width,
    input  logic [CFG_W-1:0]   source_height,
    input  logic [QLVL_W-1:0]  q_level,
    output logic               q_push,
    output imtt_pix_t          q_data
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        if (32'(d) > MAX_DIMENSION)
            return CFG_W'(MAX_DIMENSION);
        return d;
    endfunction

    // tiles per side: padded power of two (at least 8) over the tile edge
    function automatic logic [TILES_W-1:0] tiles_for(input logic [CFG_W-1:0] d);
        logic [CFG_W:0] p;
        p = (CFG_W + 1)'(1) << CFG_W;
        for (int i = CFG_W; i >= 3; i--)
        begin
            if (((CFG_W + 1)'(1) << i) >= {1'b0, d})
                p = (CFG_W + 1)'(1) << i;
        end
        return p[CFG_W:3];
    endfunction

    function automatic logic [TEXEL_W-1:0] to_rgba5551(input logic [15:0] c);
        return {c[15:11], c[10:6], c[4:0], 1'b1};
    endfunction

    logic [15:0]        palette_mem [PALETTE_ENTRIES];

    logic [CFG_W-1:0]   sw_eff, sh_eff;
    logic [TILES_W-1:0] tiles_x, tiles_y;
    logic [POS_W-1:0]   pix_reg, pix_next;
    logic [CFG_W-1:0]   col_reg, col_next;
    logic [CFG_W-1:0]   row_reg, row_next;

    logic               s1_valid_reg;
    logic               keep_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               last_tex_reg;
    logic [15:0]        pal_q_reg;

    logic               accept, pix_acc, pal_wr;
    logic               in_src, idx_ok, col_last, row_last, tile_end;

    // sizes follow the registers directly, so a request just after a write sees them
    assign sw_eff  = clamp_dim(source_width);
    assign sh_eff  = clamp_dim(source_height);
    assign tiles_x = tiles_for(sw_eff);
    assign tiles_y = tiles_for(sh_eff);

    assign full    = ({1'b0, q_level} + (QLVL_W + 1)'(s1_valid_reg))
                     >= (QLVL_W + 1)'(QUEUE_DEPTH);
    assign accept  = push && !full;
    assign pix_acc = accept && (mode == MODE_PIXEL);
    assign pal_wr  = accept && (mode == MODE_PALETTE)
                     && ({1'b0, palette_address} < 9'(PALETTE_ENTRIES));

    assign in_src  = ({col_reg, pix_reg[2:0]} < {3'b0, sw_eff})
                     && ({row_reg, pix_reg[5:3]} < {3'b0, sh_eff});
    assign idx_ok  = (pixel_index != 8'd0) && ({1'b0, pixel_index} < 9'(PALETTE_ENTRIES));

    assign col_last = ({1'b0, col_reg} + 12'd1) >= {3'b0, tiles_x};
    assign row_last = ({1'b0, row_reg} + 12'd1) >= {3'b0, tiles_y};
    assign tile_end = (pix_reg == POS_W'(TILE_TEXELS - 1));

    always_comb
    begin
        pix_next = pix_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (pix_acc)
        begin
            pix_next = pix_reg + POS_W'(1);
            if (tile_end)
            begin
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_last ? '0 : row_reg + CFG_W'(1);
                end
                else
                begin
                    col_next = col_reg + CFG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr)
            palette_mem[palette_address[PAL_AW-1:0]] <= palette_color;
        if (pix_acc)
        begin
            pal_q_reg    <= palette_mem[pixel_index[PAL_AW-1:0]];
            keep_reg     <= in_src && idx_ok;
            pos_reg      <= pix_reg;
            last_tex_reg <= col_last && row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pix_reg      <= pix_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= pix_acc;
        end
    end

    assign q_push          = s1_valid_reg;
    assign q_data.texel    = keep_reg ? to_rgba5551(pal_q_reg) : '0;
    assign q_data.pos      = pos_reg;
    assign q_data.last_tex = last_tex_reg;

endmodule

### src/imtt_fifo.sv
// Short queue of converted pixels between front and back ends.
module imtt_fifo
    import imtt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  imtt_pix_t         din,
    input  logic              pop,
    output imtt_pix_t         dout,
    output logic              empty,
    output logic [QLVL_W-1:0] level
);

    imtt_pix_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QLVL_W'(1);
        else if (pop && !push)
            count_next = count_reg - QLVL_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    assign dout  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign level = count_reg;

endmodule

### src/imtt_back.sv
// Back end: ping-pong tile store and Morton-order readout.
module imtt_back
    import imtt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  imtt_pix_t          q_data,
    output logic               q_pop,
    output logic [TEXEL_W-1:0] texel,
    output logic               last_of_tile,
    output logic               last_of_texture,
    output logic               empty,
    input  logic               pop
);

    // output k takes x from k bits 4,2,0 and y from k bits 5,3,1
    function automatic logic [POS_W-1:0] morton_addr(input logic [POS_W-1:0] k);
        return {k[5], k[3], k[1], k[4], k[2], k[0]};
    endfunction

    logic [TEXEL_W-1:0] tile_mem [2 * TILE_TEXELS];

    logic               wb_reg, rb_reg;
    logic [1:0]         full_reg, full_next;
    logic [1:0]         blast_reg;
    logic [POS_W-1:0]   k_reg;
    logic               out_valid_reg;
    logic [TEXEL_W-1:0] texel_reg;
    logic               lt_reg, ltex_reg;

    logic               wr_done, rd_issue, rd_last, out_take;

    assign q_pop    = !q_empty && !full_reg[wb_reg];
    assign wr_done  = q_pop && (q_data.pos == POS_W'(TILE_TEXELS - 1));
    assign out_take = pop && out_valid_reg;
    assign rd_issue = full_reg[rb_reg] && (!out_valid_reg || out_take);
    assign rd_last  = rd_issue && (k_reg == POS_W'(TILE_TEXELS - 1));

    // set and clear never hit the same bank in one cycle
    always_comb
    begin
        full_next = full_reg;
        if (wr_done)
            full_next[wb_reg] = 1'b1;
        if (rd_last)
            full_next[rb_reg] = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            tile_mem[{wb_reg, q_data.pos}] <= q_data.texel;
        if (rd_issue)
        begin
            texel_reg <= tile_mem[{rb_reg, morton_addr(k_reg)}];
            lt_reg    <= (k_reg == POS_W'(TILE_TEXELS - 1));
            ltex_reg  <= (k_reg == POS_W'(TILE_TEXELS - 1)) && blast_reg[rb_reg];
        end
        if (wr_done)
            blast_reg[wb_reg] <= q_data.last_tex;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_reg        <= 1'b0;
            rb_reg        <= 1'b0;
            full_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
            if (wr_done)
                wb_reg <= !wb_reg;
            if (rd_last)
                rb_reg <= !rb_reg;
            if (rd_issue)
                k_reg <= k_reg + POS_W'(1);
            if (rd_issue)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    assign texel           = texel_reg;
    assign last_of_tile    = lt_reg;
    assign last_of_texture = ltex_reg;
    assign empty           = !out_valid_reg;

endmodule

### src/indexed_to_morton_tiled_texture.sv
// Top level: configuration registers and the front, queue and back ends.
// Takes one request per cycle while full is low; a palette write waits on full too.
// A taken pixel is registered in the front end, queued, then written into the two-bank
// tile store, which has a single read port; once a tile's 64th pixel is written, its
// texels are shown in Morton order, one per cycle while pop is held; one bank fills while
// the other drains. Reset clears counters and queues and sets both sizes to 8;
// palette and tile store contents are undefined until written.
module indexed_to_morton_tiled_texture
    import imtt_pkg::*;
#(
    parameter int MAX_DIMENSION   = MAX_DIM_DEF,
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic [7:0]         pixel_index,
    input  logic [7:0]         palette_address,
    input  logic [15:0]        palette_color,
    output logic               empty,
    input  logic               pop,
    output logic [TEXEL_W-1:0] texel,
    output logic               last_of_tile,
    output logic               last_of_texture
);

    logic [CFG_W-1:0]  src_w_reg, src_h_reg;
    logic              cfg_wr;
    imtt_reg_t         reg_sel;

    logic              q_push, q_pop, q_empty;
    imtt_pix_t         q_in, q_out;
    logic [QLVL_W-1:0] q_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = imtt_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_W'(8);
            src_h_reg <= CFG_W'(8);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_SRC_WIDTH:  src_w_reg <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: src_h_reg <= pwdata[CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SRC_WIDTH:  prdata = {{(32 - CFG_W){1'b0}}, src_w_reg};
            REG_SRC_HEIGHT: prdata = {{(32 - CFG_W){1'b0}}, src_h_reg};
            default:        prdata = '0;
        endcase
    end

    imtt_front #(
        .MAX_DIMENSION   (MAX_DIMENSION),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .pixel_index     (pixel_index),
        .palette_address (palette_address),
        .palette_color   (palette_color),
        .source_width    (src_w_reg),
        .source_height   (src_h_reg),
        .q_level         (q_level),
        .q_push          (q_push),
        .q_data          (q_in)
    );

    imtt_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty),
        .level (q_level)
    );

    imtt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .texel           (texel),
        .last_of_tile    (last_of_tile),
        .last_of_texture (last_of_texture),
        .empty           (empty),
        .pop             (pop)
    );

endmodule
